### hw/rtl/voxel_obstacle_inflation_unit_defines.svh
// Assertion macros shared by the voxel obstacle inflation RTL.
`ifndef VOXEL_OBSTACLE_INFLATION_UNIT_DEFINES_SVH
`define VOXEL_OBSTACLE_INFLATION_UNIT_DEFINES_SVH

// Checked property that is ignored while reset is held.
`define VOI_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked property that also holds through reset.
`define VOI_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/voi_pkg.sv
// Shared types, widths and constants of the voxel obstacle inflation unit.
`timescale 1ns / 1ps

package voi_pkg;

  // Default map size in cells per axis.
  localparam int X_CELLS_DEF = 256;
  localparam int Y_CELLS_DEF = 256;
  localparam int Z_CELLS_DEF = 16;

  // Field widths.
  localparam int COORD_W = 20;
  localparam int RES_W   = 12;
  localparam int INV_W   = 25;
  localparam int STEP_W  = 2;
  localparam int CELL_W  = 14;
  localparam int MASK_W  = 3;

  // Datapath widths: coordinate minus corner, product and floored index.
  localparam int OFF_W  = RES_W + STEP_W;
  localparam int DIFF_W = COORD_W + 2;
  localparam int FRAC_W = 24;
  localparam int PROD_W = DIFF_W + INV_W;
  localparam int IDX_W  = PROD_W - FRAC_W;
  localparam int SLOT_W = 3;

  // Stream payload widths, padded to whole bytes.
  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 48;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 25;

  localparam logic [CFG_IDX_W-1:0] CFG_LOWER_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOWER_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOWER_Z   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RES_MM    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_RES   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_INF_STEP  = 3'd5;

  // Register values after reset.
  localparam logic signed [COORD_W-1:0] LOWER_X_RST = -20'sd60000;
  localparam logic signed [COORD_W-1:0] LOWER_Y_RST = -20'sd60000;
  localparam logic signed [COORD_W-1:0] LOWER_Z_RST = 20'sd0;
  localparam logic [RES_W-1:0]          RES_RST     = 12'd150;
  localparam logic [INV_W-1:0]          INV_RST     = 25'd111848;
  localparam logic [STEP_W-1:0]         STEP_RST    = 2'd2;

  // Saturation bounds of reported cell indices.
  localparam logic signed [IDX_W-1:0] SAT_HI = IDX_W'(8191);
  localparam logic signed [IDX_W-1:0] SAT_LO = IDX_W'(-8192);

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SETUP,
    ST_ZMUL,
    ST_YMUL,
    ST_XMUL,
    ST_XWAIT,
    ST_RD,
    ST_WR
  } voi_state_t;

  // Where a finished index is written back.
  typedef enum logic [1:0] {
    DST_Z,
    DST_Y,
    DST_X
  } mul_dst_t;

  // Tag that travels with one multiplication through the index unit.
  typedef struct packed {
    logic              vld;
    mul_dst_t          dst;
    logic [SLOT_W-1:0] slot;
  } mul_tag_t;

  // Clamp an index to the reported 14-bit range.
  function automatic logic [CELL_W-1:0] sat_cell(input logic signed [IDX_W-1:0] v);
    logic [CELL_W-1:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI[CELL_W-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[CELL_W-1:0];
    end else begin
      r = v[CELL_W-1:0];
    end
    return r;
  endfunction

endpackage

### hw/rtl/voi_index_unit.sv
// Shared index unit: multiplies an offset by the Q24 reciprocal and floors it.
`timescale 1ns / 1ps

module voi_index_unit import voi_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  mul_tag_t                 issue_tag,
  input  logic signed [DIFF_W-1:0] diff,
  input  logic [INV_W-1:0]         inv,
  output mul_tag_t                 wb_tag,
  output logic signed [IDX_W-1:0]  wb_index
);

  logic signed [DIFF_W+INV_W:0] mul_full;
  logic signed [PROD_W-1:0]     prod_r;
  mul_tag_t                     tag_r;

  // The reciprocal is unsigned, so it gets a zero sign bit.
  assign mul_full = diff * $signed({1'b0, inv});

  // One product per cycle, registered with its tag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r <= '0;
    end else begin
      tag_r <= issue_tag;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_full[PROD_W-1:0];
  end

  // Dropping the fraction bits of a two's complement product rounds toward minus infinity.
  assign wb_tag   = tag_r;
  assign wb_index = prod_r[PROD_W-1:FRAC_W];

endmodule

### hw/rtl/voxel_obstacle_inflation_unit.sv
// Top level of the voxel obstacle inflation unit.
`timescale 1ns / 1ps

// Each obstacle point marks a box of voxels around it in an occupancy store of
// X_CELLS*Y_CELLS rows of Z_CELLS bits, one row per xy column, and returns one
// transfer per column with the column's indices and a mask of the z cells that
// became occupied; out_tlast marks the point's final column. With N equal to
// 2*inflate_step+1 (5 at the reset step of two), a point covers N*N columns,
// and in_tready stays low while it is in work, also while the output stalls:
// the single multiplier of the index unit works out every x, y and z index in
// turn, and each column is one read-modify-write of the single-port occupancy
// store. After reset the store is cleared one row per cycle, X_CELLS*Y_CELLS
// rows in all, before the first point is taken; configuration writes are
// taken at any time.

`include "voxel_obstacle_inflation_unit_defines.svh"

module voxel_obstacle_inflation_unit import voi_pkg::*; #(
  parameter int X_CELLS = X_CELLS_DEF,
  parameter int Y_CELLS = Y_CELLS_DEF,
  parameter int Z_CELLS = Z_CELLS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Configuration write port.
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  // Obstacle points.
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // point_x [19:0], point_y [39:20], point_z [59:40], zero [63:60]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // Column results.
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // cell_x [13:0], cell_y [27:14], cell_z_mid [41:28], new_mask [44:42], zero [47:45]
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tlast
);

  localparam int ROWS   = X_CELLS * Y_CELLS;
  localparam int ROW_AW = $clog2(ROWS);
  localparam int XAW    = $clog2(X_CELLS);
  localparam int YAW    = $clog2(Y_CELLS);
  localparam int ZAW    = $clog2(Z_CELLS);

  // Configuration registers.
  logic signed [COORD_W-1:0] lower_x_r, lower_y_r, lower_z_r;
  logic [RES_W-1:0]          res_r;
  logic [INV_W-1:0]          inv_r;
  logic [STEP_W-1:0]         step_r;

  // Sequencer.
  voi_state_t state_r, state_nxt;
  logic [SLOT_W-1:0] cnt_r, cnt_nxt;
  logic [SLOT_W-1:0] dx_r, dx_nxt;
  logic [SLOT_W-1:0] dy_r, dy_nxt;
  logic [SLOT_W-1:0] span_r;
  logic [ROW_AW-1:0] clr_r, clr_nxt;

  // Point and running offsets from the map corner.
  logic signed [COORD_W-1:0] px_r, py_r, pz_r;
  logic [OFF_W-1:0]          soff_r;
  logic [OFF_W-1:0]          soff;
  logic signed [DIFF_W-1:0]  diffx_r, diffx_nxt;
  logic signed [DIFF_W-1:0]  diffy_r, diffy_nxt;
  logic signed [DIFF_W-1:0]  diffz_r, diffz_nxt;
  logic signed [DIFF_W-1:0]  soff_ext, res_ext;

  // Index unit.
  mul_tag_t                 issue_tag, wb_tag;
  logic signed [DIFF_W-1:0] mul_diff;
  logic signed [IDX_W-1:0]  wb_index;

  // Computed indices.
  logic signed [IDX_W-1:0] ix_r;
  logic signed [IDX_W-1:0] iy_r [7];
  logic signed [IDX_W-1:0] iz_r [3];

  // Column access.
  logic signed [IDX_W-1:0] iy_cur;
  logic                    col_ok, col_ok_r;
  logic [ROW_AW-1:0]       rd_addr, addr_r;
  logic [Z_CELLS-1:0]      occ_mem [ROWS];
  logic [Z_CELLS-1:0]      rdata_r;
  logic [Z_CELLS-1:0]      row_new;
  logic [MASK_W-1:0]       mask_new;
  logic                    mem_we;
  logic [ROW_AW-1:0]       mem_waddr;
  logic [Z_CELLS-1:0]      mem_wdata;
  logic                    col_last;
  logic                    out_load;

  // Output register.
  logic                  out_valid_r;
  logic [CELL_W-1:0]     out_x_r, out_y_r, out_z_r;
  logic [MASK_W-1:0]     out_mask_r;
  logic                  out_last_r;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lower_x_r <= LOWER_X_RST;
      lower_y_r <= LOWER_Y_RST;
      lower_z_r <= LOWER_Z_RST;
      res_r     <= RES_RST;
      inv_r     <= INV_RST;
      step_r    <= STEP_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LOWER_X:  lower_x_r <= cfg_wdata[COORD_W-1:0];
        CFG_LOWER_Y:  lower_y_r <= cfg_wdata[COORD_W-1:0];
        CFG_LOWER_Z:  lower_z_r <= cfg_wdata[COORD_W-1:0];
        CFG_RES_MM:   res_r     <= cfg_wdata[RES_W-1:0];
        CFG_INV_RES:  inv_r     <= cfg_wdata[INV_W-1:0];
        CFG_INF_STEP: step_r    <= cfg_wdata[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // Offset of the first neighbor: inflate_step times the resolution.
  always_comb begin
    case (step_r)
      2'd0:    soff = '0;
      2'd1:    soff = OFF_W'(res_r);
      2'd2:    soff = OFF_W'({res_r, 1'b0});
      default: soff = OFF_W'(res_r) + OFF_W'({res_r, 1'b0});
    endcase
  end

  assign soff_ext = $signed({{(DIFF_W-OFF_W){1'b0}}, soff_r});
  assign res_ext  = $signed({{(DIFF_W-RES_W){1'b0}}, res_r});

  assign in_tready = (state_r == ST_IDLE);

  // Latch the point when it is taken.
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      px_r   <= in_tdata[COORD_W-1:0];
      py_r   <= in_tdata[2*COORD_W-1:COORD_W];
      pz_r   <= in_tdata[3*COORD_W-1:2*COORD_W];
      soff_r <= soff;
      span_r <= {step_r, 1'b0};
    end
  end

  // Column range check and row address.
  assign iy_cur = iy_r[dy_r];
  assign col_ok = !ix_r[IDX_W-1] && (ix_r[IDX_W-2:0] < (IDX_W-1)'(X_CELLS)) &&
                  !iy_cur[IDX_W-1] && (iy_cur[IDX_W-2:0] < (IDX_W-1)'(Y_CELLS));

  always_comb begin
    rd_addr = '0;
    if (col_ok) begin
      rd_addr = ROW_AW'(ROW_AW'(ix_r[XAW-1:0]) * ROW_AW'(Y_CELLS)) +
                ROW_AW'(iy_cur[YAW-1:0]);
    end
  end

  // Set the z cells of the column, lowest first; a repeated cell counts once.
  always_comb begin
    row_new  = rdata_r;
    mask_new = '0;
    for (int k = 0; k < 3; k++) begin
      if (col_ok_r && !iz_r[k][IDX_W-1] &&
          (iz_r[k][IDX_W-2:0] < (IDX_W-1)'(Z_CELLS)) &&
          !row_new[iz_r[k][ZAW-1:0]]) begin
        row_new[iz_r[k][ZAW-1:0]] = 1'b1;
        mask_new[k]               = 1'b1;
      end
    end
  end

  assign out_load = (state_r == ST_WR) && (!out_valid_r || out_tready);
  assign col_last = (dy_r == span_r) && (dx_r == span_r);

  // Single write port: clearing pass or column write-back.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr_r;
    mem_wdata = row_new;
    if (state_r == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_r;
      mem_wdata = '0;
    end else if (out_load && col_ok_r) begin
      mem_we = 1'b1;
    end
  end

  // Occupancy store.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      occ_mem[mem_waddr] <= mem_wdata;
    end
    if (state_r == ST_RD) begin
      rdata_r <= occ_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_RD) begin
      addr_r   <= rd_addr;
      col_ok_r <= col_ok;
    end
  end

  // Index unit feed.
  always_comb begin
    issue_tag = '0;
    mul_diff  = diffx_r;
    case (state_r)
      ST_ZMUL: begin
        issue_tag = '{vld: 1'b1, dst: DST_Z, slot: cnt_r};
        mul_diff  = diffz_r;
      end
      ST_YMUL: begin
        issue_tag = '{vld: 1'b1, dst: DST_Y, slot: cnt_r};
        mul_diff  = diffy_r;
      end
      ST_XMUL: begin
        issue_tag = '{vld: 1'b1, dst: DST_X, slot: '0};
      end
      default: ;
    endcase
  end

  voi_index_unit u_index (
    .clk       (clk),
    .rst_n     (rst_n),
    .issue_tag (issue_tag),
    .diff      (mul_diff),
    .inv       (inv_r),
    .wb_tag    (wb_tag),
    .wb_index  (wb_index)
  );

  // Write back finished indices.
  always_ff @(posedge clk) begin
    if (wb_tag.vld) begin
      case (wb_tag.dst)
        DST_Z:   iz_r[wb_tag.slot[1:0]] <= wb_index;
        DST_Y:   iy_r[wb_tag.slot]      <= wb_index;
        DST_X:   ix_r                   <= wb_index;
        default: ;
      endcase
    end
  end

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r   <= '0;
      cnt_r   <= '0;
      dx_r    <= '0;
      dy_r    <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      cnt_r   <= cnt_nxt;
      dx_r    <= dx_nxt;
      dy_r    <= dy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    diffx_r <= diffx_nxt;
    diffy_r <= diffy_nxt;
    diffz_r <= diffz_nxt;
  end

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    cnt_nxt   = cnt_r;
    dx_nxt    = dx_r;
    dy_nxt    = dy_r;
    diffx_nxt = diffx_r;
    diffy_nxt = diffy_r;
    diffz_nxt = diffz_r;
    unique case (state_r)
      ST_CLEAR: begin
        clr_nxt = clr_r + 1'b1;
        if (clr_r == ROW_AW'(ROWS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = ST_SETUP;
        end
      end
      ST_SETUP: begin
        diffx_nxt = DIFF_W'(px_r) - soff_ext - DIFF_W'(lower_x_r);
        diffy_nxt = DIFF_W'(py_r) - soff_ext - DIFF_W'(lower_y_r);
        diffz_nxt = DIFF_W'(pz_r) - res_ext - DIFF_W'(lower_z_r);
        cnt_nxt   = '0;
        state_nxt = ST_ZMUL;
      end
      ST_ZMUL: begin
        diffz_nxt = diffz_r + res_ext;
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r == SLOT_W'(2)) begin
          cnt_nxt   = '0;
          state_nxt = ST_YMUL;
        end
      end
      ST_YMUL: begin
        diffy_nxt = diffy_r + res_ext;
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r == span_r) begin
          dx_nxt    = '0;
          state_nxt = ST_XMUL;
        end
      end
      ST_XMUL: begin
        dy_nxt    = '0;
        state_nxt = ST_XWAIT;
      end
      ST_XWAIT: begin
        state_nxt = ST_RD;
      end
      ST_RD: begin
        state_nxt = ST_WR;
      end
      ST_WR: begin
        if (out_load) begin
          if (dy_r != span_r) begin
            dy_nxt    = dy_r + 1'b1;
            state_nxt = ST_RD;
          end else if (dx_r != span_r) begin
            dx_nxt    = dx_r + 1'b1;
            diffx_nxt = diffx_r + res_ext;
            state_nxt = ST_XMUL;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  // Output register: holds one column result until it is transferred.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_x_r    <= sat_cell(ix_r);
      out_y_r    <= sat_cell(iy_cur);
      out_z_r    <= sat_cell(iz_r[1]);
      out_mask_r <= mask_new;
      out_last_r <= col_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W-3*CELL_W-MASK_W){1'b0}}, out_mask_r, out_z_r, out_y_r, out_x_r};
  assign out_tlast  = out_last_r;

  // Nothing leaves the block while the store is being cleared.
  `VOI_ASSERT_ALWAYS(a_no_out_in_clear, (state_r == ST_CLEAR) |-> !out_tvalid, "result during clearing pass")

  // A column outside the map never reports a new cell.
  `VOI_ASSERT(a_off_map_mask, (out_load && !col_ok_r) |=> (out_mask_r == '0), "new cell outside map")

  // A new point is only taken once every column of the previous one has been produced.
  `VOI_ASSERT(a_point_order, (in_tvalid && in_tready) |-> !(out_tvalid && !out_tlast), "point taken mid-run")

endmodule
